// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/pidsc_pkg.sv
// shared widths, register indexes, reset values and constants of the pid steer/speed core
// no dependencies
`default_nettype none

package pidsc_pkg;

	// field widths
	localparam int ERR_W    = 24;
	localparam int MODE_W   = 3;
	localparam int GAIN_W   = 24;
	localparam int LIMIT_W  = 23;
	localparam int STEER_W  = 24;
	localparam int SPEED_W  = 18;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	// pid sum: Q.32 products brought back to Q20.8
	localparam int ACC_W = 52;
	localparam int PID_W = 28;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP_ALT_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT   = 3'd4;

	// register reset values
	localparam logic [GAIN_W-1:0]  KP_GAIN_RST     = 24'd8388608;
	localparam logic [GAIN_W-1:0]  KP_ALT_GAIN_RST = 24'd7549747;
	localparam logic [GAIN_W-1:0]  KI_GAIN_RST     = 24'd1678;
	localparam logic [GAIN_W-1:0]  KD_GAIN_RST     = 24'd167772;
	localparam logic [LIMIT_W-1:0] INT_LIMIT_RST   = 23'd12800;

	// drive modes
	localparam logic [MODE_W-1:0] MODE_STOP    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PROF_1  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PROF_2  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PROF_3  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PROF_4  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_PROF_5  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_HOLD_A  = 3'd6;
	localparam logic [MODE_W-1:0] MODE_HOLD_B  = 3'd7;

	// run status codes
	localparam logic [STATUS_W-1:0] STATUS_STOP = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RUN  = 2'd2;

	// steer clamps in Q16.8
	localparam logic signed [PID_W-1:0] CLAMP_60 = 28'sd15360;
	localparam logic signed [PID_W-1:0] CLAMP_70 = 28'sd17920;
	localparam logic signed [PID_W-1:0] SAT_MAX  = 28'sd8388607;
	localparam logic signed [PID_W-1:0] SAT_MIN  = -28'sd8388608;

	// speeds in Q2.16
	localparam logic [SPEED_W-1:0] SPEED_1P6 = 18'd104858;
	localparam logic [SPEED_W-1:0] SPEED_1P8 = 18'd117965;
	localparam logic [SPEED_W-1:0] SPEED_2P0 = 18'd131072;
	localparam logic [SPEED_W-1:0] SPEED_1P0 = 18'd65536;
	localparam logic [SPEED_W-1:0] SPEED_1P4 = 18'd91750;

	// speed drop: q = (x * RECIP) >> RECIP_SH, exact for x below 2^23
	localparam int DROP_X_W  = 23;
	localparam int RECIP_W   = 25;
	localparam int RECIP_SH  = 31;
	localparam int DROP_Q_W  = 17;
	localparam logic [RECIP_W-1:0]  RECIP_200 = 25'd10737419;
	localparam logic [RECIP_W-1:0]  RECIP_120 = 25'd17895698;
	localparam logic [RECIP_W-1:0]  RECIP_100 = 25'd21474837;
	localparam logic [DROP_X_W-1:0] HALF_200  = 23'd100;
	localparam logic [DROP_X_W-1:0] HALF_120  = 23'd60;
	localparam logic [DROP_X_W-1:0] HALF_100  = 23'd50;

endpackage

`default_nettype wire

// File: rtl/core/pid_steer_speed_controller_core.sv
// pid steer and speed controller: integral-clamped pid with per-mode steer clamp and speed law
// depends on pidsc_pkg
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+------------------------------------
//   sample   | in        | sample_valid / sample_stall | error_sample, drive_mode, started
//   result   | out       | result_valid / result_stall | steer_value, speed_value, run_status
//   cfg      | in        | cfg_write                   | cfg_index, cfg_data
//
// one item per cycle unless result_stall holds; items pass stage 1, stage 2 and the result register
// stage 1 holds the three gain multiplies and the integral clamp, stage 2 the
// speed-drop reciprocal multiply and the mode laws, then the result register
// a stalled result holds the pipe; stall towards the sample side rises only when all stages are full
// reset clears valids, gains to their defaults, integral, last error and held speed
`default_nettype none

module pid_steer_speed_controller_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  sample_valid,
	output logic                                 sample_stall,
	input  wire  signed [pidsc_pkg::ERR_W-1:0]   error_sample,
	input  wire         [pidsc_pkg::MODE_W-1:0]  drive_mode,
	input  wire                                  started,
	output logic                                 result_valid,
	input  wire                                  result_stall,
	output logic signed [pidsc_pkg::STEER_W-1:0] steer_value,
	output logic        [pidsc_pkg::SPEED_W-1:0] speed_value,
	output logic        [pidsc_pkg::STATUS_W-1:0] run_status,
	input  wire                                  cfg_write,
	input  wire         [pidsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire         [pidsc_pkg::CFG_DAT_W-1:0] cfg_data
);
	import pidsc_pkg::*;

	// configuration
	logic [GAIN_W-1:0]  kp_q, kp_alt_q, ki_q, kd_q;
	logic [LIMIT_W-1:0] limit_q;

	// state
	logic signed [ERR_W-1:0]   integral_q;
	logic signed [ERR_W-1:0]   last_error_q;
	logic        [SPEED_W-1:0] held_speed_q;

	// stage 1: input register
	logic                     valid_s1;
	logic signed [ERR_W-1:0]  error_s1;
	logic        [MODE_W-1:0] mode_s1;
	logic                     started_s1;

	// stage 2
	logic                     valid_s2;
	logic signed [PID_W-1:0]  pid_s2;
	logic        [MODE_W-1:0] mode_s2;
	logic                     started_s2;

	// result register
	logic                        result_valid_q;
	logic signed [STEER_W-1:0]   steer_q;
	logic        [SPEED_W-1:0]   speed_q;
	logic        [STATUS_W-1:0]  status_q;

	// flow control
	logic out_load, load2, load1, adv1, adv2, accept;

	assign out_load     = !result_valid_q || !result_stall;
	assign adv2         = valid_s2 && out_load;
	assign load2        = !valid_s2 || out_load;
	assign adv1         = valid_s1 && load2;
	assign load1        = !valid_s1 || load2;
	assign accept       = sample_valid && load1;
	assign sample_stall = !load1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= KP_GAIN_RST;
			kp_alt_q <= KP_ALT_GAIN_RST;
			ki_q     <= KI_GAIN_RST;
			kd_q     <= KD_GAIN_RST;
			limit_q  <= INT_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KP_GAIN:     kp_q     <= cfg_data[GAIN_W-1:0];
				REG_KP_ALT_GAIN: kp_alt_q <= cfg_data[GAIN_W-1:0];
				REG_KI_GAIN:     ki_q     <= cfg_data[GAIN_W-1:0];
				REG_KD_GAIN:     kd_q     <= cfg_data[GAIN_W-1:0];
				REG_INT_LIMIT:   limit_q  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 arithmetic
	logic signed [ERR_W:0]     isum, diff, lim_pos, lim_neg;
	logic        [GAIN_W-1:0]  kp_sel;
	logic signed [48:0]        prod_p;
	logic signed [49:0]        prod_i, prod_d;
	logic signed [ACC_W-1:0]   acc;
	logic signed [PID_W-1:0]   pid_next;
	logic signed [ERR_W-1:0]   integral_next;

	always_comb begin
		isum    = {integral_q[ERR_W-1], integral_q} + {error_s1[ERR_W-1], error_s1};
		diff    = {error_s1[ERR_W-1], error_s1} - {last_error_q[ERR_W-1], last_error_q};
		kp_sel  = (mode_s1 == MODE_PROF_2 || mode_s1 == MODE_PROF_3) ? kp_alt_q : kp_q;
		prod_p  = $signed({1'b0, kp_sel}) * error_s1;
		prod_i  = $signed({1'b0, ki_q}) * isum;
		prod_d  = $signed({1'b0, kd_q}) * diff;
		// round half up, then floor shift back to Q20.8
		acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d)
			+ $signed({{(ACC_W-24){1'b0}}, 24'h800000});
		pid_next = acc[ACC_W-1:24];
		lim_pos = $signed({2'b00, limit_q});
		lim_neg = -lim_pos;
		if (isum > lim_pos)
			integral_next = lim_pos[ERR_W-1:0];
		else if (isum < lim_neg)
			integral_next = lim_neg[ERR_W-1:0];
		else
			integral_next = isum[ERR_W-1:0];
	end

	// stage 2 arithmetic
	logic signed [PID_W-1:0]   clamp60, clamp70, sat24;
	logic        [14:0]        abs60, abs70, drop_abs;
	logic        [RECIP_W-1:0] recip;
	logic        [DROP_X_W-1:0] half, drop_x;
	logic        [47:0]        drop_prod;
	logic        [DROP_Q_W-1:0] drop_q;
	logic        [SPEED_W-1:0] base_speed;
	logic signed [STEER_W-1:0] steer_next;
	logic        [SPEED_W-1:0] speed_next;
	logic        [STATUS_W-1:0] status_next;

	always_comb begin
		if (pid_s2 > CLAMP_60)       clamp60 = CLAMP_60;
		else if (pid_s2 < -CLAMP_60) clamp60 = -CLAMP_60;
		else                         clamp60 = pid_s2;
		if (pid_s2 > CLAMP_70)       clamp70 = CLAMP_70;
		else if (pid_s2 < -CLAMP_70) clamp70 = -CLAMP_70;
		else                         clamp70 = pid_s2;
		if (pid_s2 > SAT_MAX)        sat24 = SAT_MAX;
		else if (pid_s2 < SAT_MIN)   sat24 = SAT_MIN;
		else                         sat24 = pid_s2;
		abs60 = clamp60[PID_W-1] ? 15'(-clamp60) : clamp60[14:0];
		abs70 = clamp70[PID_W-1] ? 15'(-clamp70) : clamp70[14:0];

		// rounded |steer| * 256 / d
		case (mode_s2)
			MODE_PROF_1: begin
				recip = RECIP_200; half = HALF_200; drop_abs = abs60; base_speed = SPEED_1P6;
			end
			MODE_PROF_2: begin
				recip = RECIP_120; half = HALF_120; drop_abs = abs60; base_speed = SPEED_1P8;
			end
			default: begin
				recip = RECIP_100; half = HALF_100; drop_abs = abs70; base_speed = SPEED_2P0;
			end
		endcase
		drop_x    = {drop_abs, 8'b0} + half;
		drop_prod = 48'(drop_x) * 48'(recip);
		drop_q    = drop_prod[RECIP_SH +: DROP_Q_W];

		case (mode_s2) inside
			MODE_PROF_1, MODE_PROF_2, MODE_PROF_3: begin
				steer_next = STEER_W'(clamp60);
				speed_next = base_speed - SPEED_W'(drop_q);
			end
			MODE_PROF_4: begin
				steer_next = STEER_W'(clamp60);
				speed_next = SPEED_1P0;
			end
			MODE_PROF_5: begin
				steer_next = STEER_W'(clamp60);
				speed_next = SPEED_1P4;
			end
			MODE_HOLD_A, MODE_HOLD_B: begin
				steer_next = STEER_W'(sat24);
				speed_next = held_speed_q;
			end
			default: begin
				steer_next = '0;
				speed_next = '0;
			end
		endcase

		if (mode_s2 != MODE_STOP) status_next = STATUS_RUN;
		else if (started_s2)      status_next = STATUS_OK;
		else                      status_next = STATUS_STOP;
	end

	// pipeline and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
			integral_q     <= '0;
			last_error_q   <= '0;
			held_speed_q   <= '0;
		end else begin
			if (load1)
				valid_s1 <= sample_valid;
			if (load2)
				valid_s2 <= valid_s1;
			if (out_load)
				result_valid_q <= valid_s2;
			// integral and last error move with the item leaving stage 1
			if (adv1) begin
				integral_q   <= integral_next;
				last_error_q <= error_s1;
			end
			if (adv2)
				held_speed_q <= speed_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			error_s1   <= error_sample;
			mode_s1    <= drive_mode;
			started_s1 <= started;
		end
		if (adv1) begin
			pid_s2     <= pid_next;
			mode_s2    <= mode_s1;
			started_s2 <= started_s1;
		end
		if (adv2) begin
			steer_q  <= steer_next;
			speed_q  <= speed_next;
			status_q <= status_next;
		end
	end

	assign result_valid = result_valid_q;
	assign steer_value  = steer_q;
	assign speed_value  = speed_q;
	assign run_status   = status_q;

endmodule

`default_nettype wire

// File: rtl/core/pidsc_checker.sv
// port-level checker for the pid steer/speed core, bound to the core module
// depends on pidsc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pidsc_checker (
	input wire                                   clk,
	input wire                                   arst_n,
	input wire                                   result_valid,
	input wire                                   result_stall,
	input wire signed [pidsc_pkg::STEER_W-1:0]   steer_value,
	input wire        [pidsc_pkg::SPEED_W-1:0]   speed_value,
	input wire        [pidsc_pkg::STATUS_W-1:0]  run_status
);
	import pidsc_pkg::*;

	// a stalled result keeps its item
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(steer_value) && $stable(speed_value) && $stable(run_status))

	// stop mode drives steer and speed to zero
	`ASSERT_IMPLIES(a_stop_zero, clk, arst_n, result_valid && run_status != STATUS_RUN, steer_value == '0 && speed_value == '0)

	// no speed law or held speed exceeds the top profile speed
	`ASSERT_IMPLIES(a_speed_bound, clk, arst_n, result_valid, speed_value <= SPEED_2P0)

	// the status never takes the unused code
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, result_valid, run_status == STATUS_STOP || run_status == STATUS_OK || run_status == STATUS_RUN)

endmodule

bind pid_steer_speed_controller_core pidsc_checker u_pidsc_checker (.*);

`default_nettype wire
